[hw/rtl/fpba_pkg.sv]
// Shared constants and codes for the fit-policy block allocator.
// No dependencies; imported by every module of the block.
package fpba_pkg;

  // default sizing, handed down from the top level
  localparam int DEF_MAX_BLOCKS = 16;
  localparam int DEF_SIZE_BITS  = 16;

  // fixed field widths of the item and result beats
  localparam int IDX_FIELD_W  = 4;
  localparam int SIZE_FIELD_W = 16;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 5;
  localparam int POLICY_W    = 2;
  localparam int NUM_BLK_W   = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_FIT_POLICY = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NUM_BLOCKS = 2'd1;

  localparam logic [POLICY_W-1:0]  POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0]  POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0]  POL_WORST = 2'd2;

  localparam logic [NUM_BLK_W-1:0] NUM_BLOCKS_RST = 5'd16;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

endpackage

[hw/rtl/fpba_table.sv]
// Free-size table: one write port, one registered read port, per-entry valid bits.
// Depends on fpba_pkg.
module fpba_table
  import fpba_pkg::*;
#(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
  parameter int SIZE_BITS  = DEF_SIZE_BITS,
  localparam int IDX_W     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  logic [SIZE_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output logic [SIZE_BITS-1:0] rd_data
);

  logic [SIZE_BITS-1:0]  mem_r [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] vld_r;
  logic [SIZE_BITS-1:0]  rd_q_r;
  logic                  rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem_r[rd_addr];
    end
  end

  // entries never loaded read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

[hw/rtl/fpba_seq.sv]
// Sequencer and shared compare unit: loads, request scan, write-back, result beat.
// Depends on fpba_pkg; drives fpba_table through the top level.
module fpba_seq
  import fpba_pkg::*;
#(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
  parameter int SIZE_BITS  = DEF_SIZE_BITS,
  localparam int IDX_W     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
  localparam int CNT_W     = ($clog2(MAX_BLOCKS + 1) > NUM_BLK_W) ?
                             $clog2(MAX_BLOCKS + 1) : NUM_BLK_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_mode,
  input  logic [IDX_FIELD_W-1:0]  in_block_index,
  input  logic [SIZE_FIELD_W-1:0] in_size,
  input  logic [POLICY_W-1:0]     fit_policy,
  input  logic [CNT_W-1:0]        scan_len,
  output logic                    tbl_wr_en,
  output logic [IDX_W-1:0]        tbl_wr_addr,
  output logic [SIZE_BITS-1:0]    tbl_wr_data,
  output logic                    tbl_rd_en,
  output logic [IDX_W-1:0]        tbl_rd_addr,
  input  logic [SIZE_BITS-1:0]    tbl_rd_data,
  output logic                    out_valid,
  output logic                    out_granted,
  output logic [IDX_FIELD_W-1:0]  out_chosen_block,
  output logic [SIZE_FIELD_W-1:0] out_remaining_size
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_WRITE = 3'b100
  } state_t;

  state_t                  state_r, state_nxt;
  logic [IDX_W-1:0]        cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0]        pick_r, pick_nxt;
  logic [SIZE_BITS-1:0]    best_val_r, best_val_nxt;
  logic [SIZE_BITS-1:0]    sz_r, sz_nxt;
  logic                    found_r, found_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_granted_r, out_granted_nxt;
  logic [IDX_FIELD_W-1:0]  out_blk_r, out_blk_nxt;
  logic [SIZE_FIELD_W-1:0] out_rem_r, out_rem_nxt;

  logic                    is_best, is_worst, is_first;
  logic                    fits, take, last, load_ok;
  logic [SIZE_BITS-1:0]    in_sz, diff;

  assign is_best  = (fit_policy == POL_BEST);
  assign is_worst = (fit_policy == POL_WORST);
  assign is_first = !is_best && !is_worst;

  assign in_sz   = SIZE_BITS'(in_size);
  assign load_ok = (32'(in_block_index) < MAX_BLOCKS);

  // shared compare unit: one entry per cycle
  assign fits = (tbl_rd_data >= sz_r);
  assign take = fits && (!found_r ||
                         (is_best  && (tbl_rd_data < best_val_r)) ||
                         (is_worst && (tbl_rd_data > best_val_r)));
  assign last = ((CNT_W'(cmp_idx_r) + CNT_W'(1)) == scan_len);
  assign diff = best_val_r - sz_r;

  always_comb begin
    state_nxt       = state_r;
    cmp_idx_nxt     = cmp_idx_r;
    pick_nxt        = pick_r;
    best_val_nxt    = best_val_r;
    sz_nxt          = sz_r;
    found_nxt       = found_r;
    out_valid_nxt   = 1'b0;
    out_granted_nxt = out_granted_r;
    out_blk_nxt     = out_blk_r;
    out_rem_nxt     = out_rem_r;
    tbl_wr_en       = 1'b0;
    tbl_wr_addr     = pick_r;
    tbl_wr_data     = diff;
    tbl_rd_en       = 1'b0;
    tbl_rd_addr     = cmp_idx_r + IDX_W'(1);
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          sz_nxt = in_sz;
          if (in_mode == MODE_LOAD) begin
            tbl_wr_en       = load_ok;
            tbl_wr_addr     = IDX_W'(in_block_index);
            tbl_wr_data     = in_sz;
            out_valid_nxt   = 1'b1;
            out_granted_nxt = load_ok;
            out_blk_nxt     = load_ok ? in_block_index : '0;
            out_rem_nxt     = load_ok ? SIZE_FIELD_W'(in_sz) : '0;
          end else if (scan_len == '0) begin
            out_valid_nxt   = 1'b1;
            out_granted_nxt = 1'b0;
            out_blk_nxt     = '0;
            out_rem_nxt     = '0;
          end else begin
            tbl_rd_en   = 1'b1;
            tbl_rd_addr = '0;
            cmp_idx_nxt = '0;
            found_nxt   = 1'b0;
            state_nxt   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (take) begin
          found_nxt    = 1'b1;
          pick_nxt     = cmp_idx_r;
          best_val_nxt = tbl_rd_data;
        end
        // first fit stops at the first entry that fits
        if (last || (is_first && fits)) begin
          state_nxt = ST_WRITE;
        end else begin
          tbl_rd_en   = 1'b1;
          cmp_idx_nxt = cmp_idx_r + IDX_W'(1);
        end
      end
      ST_WRITE: begin
        tbl_wr_en       = found_r;
        out_valid_nxt   = 1'b1;
        out_granted_nxt = found_r;
        out_blk_nxt     = found_r ? IDX_FIELD_W'(pick_r) : '0;
        out_rem_nxt     = found_r ? SIZE_FIELD_W'(diff) : '0;
        state_nxt       = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r     <= cmp_idx_nxt;
    pick_r        <= pick_nxt;
    best_val_r    <= best_val_nxt;
    sz_r          <= sz_nxt;
    found_r       <= found_nxt;
    out_granted_r <= out_granted_nxt;
    out_blk_r     <= out_blk_nxt;
    out_rem_r     <= out_rem_nxt;
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_granted        = out_granted_r;
  assign out_chosen_block   = out_blk_r;
  assign out_remaining_size = out_rem_r;

endmodule

[hw/rtl/fit_policy_block_allocator_core.sv]
// Top level of the fit-policy block allocator: config registers, table, sequencer.
// Depends on fpba_pkg, fpba_table and fpba_seq.
//
// Fit-policy block allocator. A beat is taken at a rising edge with start high and
// busy low. A load beat (mode 0) writes one table entry if its index is below
// MAX_BLOCKS and is acknowledged by a result beat on the next cycle. A request beat
// (mode 1) walks entries 0 .. min(num_blocks, MAX_BLOCKS)-1 one per cycle through
// the table's single registered read port and one shared comparator, then writes
// the reduced size back if an entry fits; busy stays high through the scan and the
// write-back (under first fit the scan stops at the first entry that fits), and the
// result beat follows in the cycle after the write-back. Each result beat is shown
// on out_* for exactly one cycle, flagged by out_valid; there is no backpressure,
// so the receiver must take it then. Registers are to be written by the user
// through cfg_we/cfg_index/cfg_wdata only while the block is idle; the block
// itself does not enforce this. Table entries read as zero until first loaded.
module fit_policy_block_allocator_core
  import fpba_pkg::*;
#(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
  parameter int SIZE_BITS  = DEF_SIZE_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // item channel
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_mode,
  input  logic [IDX_FIELD_W-1:0]  in_block_index,
  input  logic [SIZE_FIELD_W-1:0] in_size,
  // result channel, one-cycle strobe
  output logic                    out_valid,
  output logic                    out_granted,
  output logic [IDX_FIELD_W-1:0]  out_chosen_block,
  output logic [SIZE_FIELD_W-1:0] out_remaining_size,
  // configuration writes
  input  logic                    cfg_we,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = ($clog2(MAX_BLOCKS + 1) > NUM_BLK_W) ?
                         $clog2(MAX_BLOCKS + 1) : NUM_BLK_W;

  logic [POLICY_W-1:0]  fit_policy_r;
  logic [NUM_BLK_W-1:0] num_blocks_r;
  logic [CNT_W-1:0]     num_ext, scan_len;

  logic                 tbl_wr_en, tbl_rd_en;
  logic [IDX_W-1:0]     tbl_wr_addr, tbl_rd_addr;
  logic [SIZE_BITS-1:0] tbl_wr_data, tbl_rd_data;

  // config registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_policy_r <= POL_FIRST;
      num_blocks_r <= NUM_BLOCKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIT_POLICY: fit_policy_r <= cfg_wdata[POLICY_W-1:0];
        REG_NUM_BLOCKS: num_blocks_r <= cfg_wdata[NUM_BLK_W-1:0];
        default: ;
      endcase
    end
  end

  // scan length clamps to the table depth
  assign num_ext  = CNT_W'(num_blocks_r);
  assign scan_len = (num_ext > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : num_ext;

  fpba_table #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  fpba_seq #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_seq (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_mode            (in_mode),
    .in_block_index     (in_block_index),
    .in_size            (in_size),
    .fit_policy         (fit_policy_r),
    .scan_len           (scan_len),
    .tbl_wr_en          (tbl_wr_en),
    .tbl_wr_addr        (tbl_wr_addr),
    .tbl_wr_data        (tbl_wr_data),
    .tbl_rd_en          (tbl_rd_en),
    .tbl_rd_addr        (tbl_rd_addr),
    .tbl_rd_data        (tbl_rd_data),
    .out_valid          (out_valid),
    .out_granted        (out_granted),
    .out_chosen_block   (out_chosen_block),
    .out_remaining_size (out_remaining_size)
  );

endmodule
